/* design/tfr_pkg.sv */
// ----------------------------------------------------------------------------
// tfr_pkg
// Shared types and codes for the timestamped frame ring.
// ----------------------------------------------------------------------------
package tfr_pkg;

  localparam int KIND_W   = 3;
  localparam int STATUS_W = 3;
  localparam int STAMP_W  = 32;
  localparam int FRAME_W  = 32;
  localparam int SIZE_W   = 10;
  localparam int DATA_W   = 64;

  localparam logic [KIND_W-1:0] KIND_HEADER  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WORD    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TAKE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CATCH_T = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CATCH_F = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DROP    = 3'd5;
  localparam logic [KIND_W-1:0] KIND_PEEK    = 3'd6;
  localparam logic [KIND_W-1:0] KIND_FLUSH   = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_SMALL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd4;

  localparam logic [STAMP_W-1:0] US_PER_MS = 32'd1000;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [FRAME_W-1:0] frame;
    logic [SIZE_W-1:0]  size;
  } meta_t;

  localparam int META_W = STAMP_W + FRAME_W + SIZE_W;

endpackage

/* design/tfr_ram.sv */
// ----------------------------------------------------------------------------
// tfr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tfr_ram #(
  parameter int ADDR_W = 3,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/timestamped_frame_ring.sv */
// ----------------------------------------------------------------------------
// timestamped_frame_ring
// Ring of frame slots with header/payload writes and take, catch-up, peek,
// drop and flush on the read side.
//
//   channel | handshake          | fields
//   --------+--------------------+------------------------------------------
//   input   | in_valid/in_stall  | kind time_ms frame_number frame_size
//           |                    | data_in capacity running
//   output  | out_valid/out_stall| status stamp_us frame_out size_out
//           |                    | data_out last fill_level underrun
//
// Header, word, drop and flush beats answer from IDLE. Take, peek and catch-up
// read the slot metadata in LOOK, pass through WAIT per head slot that a catch-up
// drops, and stream each payload word via FETCH (payload RAM read) and PUT
// (output load). Reset is synchronous and empties the ring; no clearing pass.
// A stall on the output holds the sequencer; input is refused meanwhile.
// ----------------------------------------------------------------------------
module timestamped_frame_ring #(
  parameter int RING_SLOTS  = 8,
  parameter int PAYLOAD_MAX = 512,
  localparam int COUNT_W    = $clog2(RING_SLOTS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tfr_pkg::KIND_W-1:0]    kind,
  input  logic [tfr_pkg::STAMP_W-1:0]   time_ms,
  input  logic [tfr_pkg::FRAME_W-1:0]   frame_number,
  input  logic [tfr_pkg::SIZE_W-1:0]    frame_size,
  input  logic [tfr_pkg::DATA_W-1:0]    data_in,
  input  logic [tfr_pkg::SIZE_W-1:0]    capacity,
  input  logic                          running,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tfr_pkg::STATUS_W-1:0]  status,
  output logic [tfr_pkg::STAMP_W-1:0]   stamp_us,
  output logic [tfr_pkg::FRAME_W-1:0]   frame_out,
  output logic [tfr_pkg::SIZE_W-1:0]    size_out,
  output logic [tfr_pkg::DATA_W-1:0]    data_out,
  output logic                          last,
  output logic [COUNT_W-1:0]            fill_level,
  output logic                          underrun
);
  import tfr_pkg::*;

  localparam int SLOT_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int WORDS  = (PAYLOAD_MAX + 7) / 8;
  localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PADDR_W = SLOT_W + WIDX_W;
  localparam logic [SIZE_W-1:0]  SIZE_MAX = SIZE_W'(PAYLOAD_MAX);
  localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(RING_SLOTS);
  localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(RING_SLOTS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;

  logic [2:0]         state;
  logic [SLOT_W-1:0]  write_ptr, read_ptr, head_slot;
  logic [COUNT_W-1:0] slot_count;
  logic [WIDX_W-1:0]  word_pos, idx;
  logic [WIDX_W:0]    nwords;
  logic               slot_open, underrun_flag;
  logic [SIZE_W-1:0]  cur_size;
  logic [KIND_W-1:0]  kind_q;
  logic [STAMP_W-1:0] target;
  logic [SIZE_W-1:0]  cap_q;
  logic               running_q;
  meta_t              head_meta;

  logic               out_free, accept;
  logic [STAMP_W-1:0] stamp_calc;
  logic [SIZE_W-1:0]  size_sat;
  logic [SIZE_W:0]    bytes_left;
  logic [DATA_W-1:0]  data_masked;
  logic [SIZE_W-1:0]  words_cur, words_head;
  meta_t              meta_wr, meta_q;
  logic               meta_we, pay_we;
  logic [DATA_W-1:0]  pay_q;
  logic [SLOT_W-1:0]  wp_inc, rp_inc;
  logic               word_done, behind;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !(state == S_IDLE && out_free);
  assign accept   = in_valid && !in_stall;

  // saturate size, scale time to microseconds
  assign stamp_calc = time_ms * US_PER_MS;
  assign size_sat   = (frame_size > SIZE_MAX) ? SIZE_MAX : frame_size;
  assign wp_inc     = (write_ptr == LAST_SLOT) ? '0 : write_ptr + 1'b1;
  assign rp_inc     = (read_ptr == LAST_SLOT) ? '0 : read_ptr + 1'b1;
  assign words_cur  = (cur_size + SIZE_W'(7)) >> 3;
  assign words_head = (meta_q.size + SIZE_W'(7)) >> 3;
  assign word_done  = (SIZE_W'(word_pos) + SIZE_W'(1)) >= words_cur;

  // zero bytes beyond the frame end
  assign bytes_left = {1'b0, cur_size} - (SIZE_W + 1)'({word_pos, 3'b000});
  always_comb begin
    data_masked = data_in;
    for (int b = 0; b < 8; b++) begin
      if (bytes_left < (SIZE_W + 1)'(b + 1)) begin
        data_masked[8*b +: 8] = 8'h00;
      end
    end
  end

  // head slot behind the catch-up target
  always_comb begin
    case (kind_q)
      KIND_CATCH_T: behind = meta_q.stamp < target;
      KIND_CATCH_F: behind = meta_q.frame < target;
      default:      behind = 1'b0;
    endcase
  end

  assign meta_we = accept && kind == KIND_HEADER && slot_count != FULL_CNT;
  assign meta_wr = '{stamp: stamp_calc, frame: frame_number, size: size_sat};
  assign pay_we  = accept && kind == KIND_WORD && slot_open;

  tfr_ram #(.ADDR_W(SLOT_W), .DATA_W(META_W)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (write_ptr),
    .wdata (meta_wr),
    .raddr (read_ptr),
    .rdata (meta_q)
  );

  tfr_ram #(.ADDR_W(PADDR_W), .DATA_W(DATA_W)) u_payload (
    .clk   (clk),
    .we    (pay_we),
    .waddr ({write_ptr, word_pos}),
    .wdata (data_masked),
    .raddr ({head_slot, idx}),
    .rdata (pay_q)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      write_ptr     <= '0;
      read_ptr      <= '0;
      slot_count    <= '0;
      word_pos      <= '0;
      slot_open     <= 1'b0;
      underrun_flag <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            kind_q    <= kind;
            cap_q     <= capacity;
            running_q <= running;
            target    <= (kind == KIND_CATCH_T) ? stamp_calc : frame_number;
            out_valid  <= 1'b1;
            status     <= ST_OK;
            stamp_us   <= '0;
            frame_out  <= '0;
            size_out   <= '0;
            data_out   <= '0;
            last       <= 1'b1;
            fill_level <= slot_count;
            underrun   <= underrun_flag;
            case (kind)
              KIND_HEADER: begin
                if (slot_count == FULL_CNT) begin
                  status <= ST_FULL;
                end else if (size_sat == '0) begin
                  write_ptr  <= wp_inc;
                  slot_count <= slot_count + 1'b1;
                  fill_level <= slot_count + 1'b1;
                  slot_open  <= 1'b0;
                  word_pos   <= '0;
                end else begin
                  cur_size  <= size_sat;
                  slot_open <= 1'b1;
                  word_pos  <= '0;
                end
              end
              KIND_WORD: begin
                if (!slot_open) begin
                  status <= ST_IGNORED;
                end else if (word_done) begin
                  write_ptr  <= wp_inc;
                  slot_count <= slot_count + 1'b1;
                  fill_level <= slot_count + 1'b1;
                  slot_open  <= 1'b0;
                  word_pos   <= '0;
                end else begin
                  word_pos <= word_pos + 1'b1;
                end
              end
              KIND_DROP: begin
                if (slot_count == '0) begin
                  status <= ST_EMPTY;
                end else begin
                  read_ptr   <= rp_inc;
                  slot_count <= slot_count - 1'b1;
                  fill_level <= slot_count - 1'b1;
                end
              end
              KIND_FLUSH: begin
                write_ptr     <= '0;
                read_ptr      <= '0;
                slot_count    <= '0;
                word_pos      <= '0;
                slot_open     <= 1'b0;
                underrun_flag <= 1'b0;
                fill_level    <= '0;
                underrun      <= 1'b0;
              end
              default: begin
                // read kinds wait for the metadata read
                out_valid <= 1'b0;
                state     <= S_LOOK;
              end
            endcase
          end
        end
        S_LOOK: begin
          if (slot_count != '0 && behind) begin
            read_ptr   <= rp_inc;
            slot_count <= slot_count - 1'b1;
            state      <= S_WAIT;
          end else if (out_free) begin
            out_valid  <= 1'b1;
            status     <= ST_OK;
            stamp_us   <= '0;
            frame_out  <= '0;
            size_out   <= '0;
            data_out   <= '0;
            last       <= 1'b1;
            fill_level <= slot_count;
            underrun   <= underrun_flag;
            state      <= S_IDLE;
            if (slot_count == '0) begin
              status <= ST_EMPTY;
              if (running_q) begin
                underrun_flag <= 1'b1;
                underrun      <= 1'b1;
              end
            end else if (kind_q == KIND_PEEK) begin
              stamp_us  <= meta_q.stamp;
              frame_out <= meta_q.frame;
              size_out  <= meta_q.size;
            end else if (cap_q < meta_q.size) begin
              status <= ST_TOO_SMALL;
            end else begin
              read_ptr      <= rp_inc;
              slot_count    <= slot_count - 1'b1;
              underrun_flag <= 1'b0;
              head_meta     <= meta_q;
              head_slot     <= read_ptr;
              idx           <= '0;
              nwords        <= (WIDX_W + 1)'(words_head);
              if (meta_q.size == '0) begin
                stamp_us   <= meta_q.stamp;
                frame_out  <= meta_q.frame;
                fill_level <= slot_count - 1'b1;
                underrun   <= 1'b0;
              end else begin
                out_valid <= 1'b0;
                state     <= S_FETCH;
              end
            end
          end
        end
        S_WAIT: begin
          state <= S_LOOK;
        end
        S_FETCH: begin
          state <= S_PUT;
        end
        S_PUT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            status     <= ST_OK;
            stamp_us   <= head_meta.stamp;
            frame_out  <= head_meta.frame;
            size_out   <= head_meta.size;
            data_out   <= pay_q;
            last       <= ({1'b0, idx} + 1'b1) == nwords;
            fill_level <= slot_count;
            underrun   <= underrun_flag;
            if (({1'b0, idx} + 1'b1) == nwords) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_FETCH;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/tfr_checker.sv */
// ----------------------------------------------------------------------------
// tfr_checker
// Port-level checks on the frame ring results.
// ----------------------------------------------------------------------------
module tfr_checker #(
  parameter int RING_SLOTS = 8,
  parameter int COUNT_W    = 4
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [tfr_pkg::STATUS_W-1:0] status,
  input logic [tfr_pkg::DATA_W-1:0]   data_out,
  input logic                         last,
  input logic [COUNT_W-1:0]           fill_level
);
  import tfr_pkg::*;

  // hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data_out) && $stable(last))
    else $error("stalled result beat changed");

  // fill level stays within the ring
  a_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fill_level <= COUNT_W'(RING_SLOTS))
    else $error("fill level beyond ring size");

  // failures end the item in one beat
  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last)
    else $error("failure beat without last");

  // empty status only on an empty ring
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> fill_level == '0)
    else $error("empty status with slots present");

endmodule

bind timestamped_frame_ring tfr_checker #(
  .RING_SLOTS (RING_SLOTS),
  .COUNT_W    (COUNT_W)
) u_tfr_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .data_out   (data_out),
  .last       (last),
  .fill_level (fill_level)
);
